// ===== rtl/core/rtdhd_pkg.sv =====
// Shared types, widths and the constant RTD table for the RTD heater drive.
// No dependencies; used by rtd_temperature_heater_drive and its testbench.
package rtdhd_pkg;

    // Table size and default number of points in use
    localparam int TABLE_POINTS      = 20;
    localparam int TABLE_ENTRIES_DEF = 20;
    localparam int SEG_W             = $clog2(TABLE_POINTS);

    // Field widths
    localparam int BC_W     = 15;
    localparam int RC_W     = 15;
    localparam int SCALE_W  = 32;
    localparam int SP_W     = 20;
    localparam int GAIN_W   = 16;
    localparam int TSCALE_W = 16;
    localparam int BV_W     = 32;
    localparam int RR_W     = 21;
    localparam int TEMP_W   = 20;
    localparam int DUTY_W   = 32;
    localparam int CFG_W    = 32;
    localparam int CFG_IDX_W = 3;

    // Q-format shift shared by the Q8.8 and Q13.8 products
    localparam int Q_SHIFT = 8;

    // Table entry widths
    localparam int RAW_W  = 13;    // reading points, up to 4096
    localparam int DEG_W  = 16;    // degree points, signed, up to 32767
    localparam int DEGL_W = 11;    // left point degrees, -242 .. 999
    localparam int DD_W   = 15;    // degree step of one segment
    localparam int DEN_W  = 11;    // reading step of one segment
    localparam int X_W    = RR_W;  // offset into a segment
    localparam int NUM_W  = DD_W + X_W;

    // Interpolated value is clamped here before the output scale:
    // 2^27 times any nonzero Q8.8 scale already saturates the temperature.
    localparam int Y_W     = 29;
    localparam int Y_CLAMP = 1 << 27;

    // Stream payload widths
    localparam int IN_FIELDS_W  = BC_W + RC_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = BV_W + RR_W + TEMP_W + DUTY_W + 1;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    // Register map
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ENABLE         = 3'd0,
        REG_BATTERY_SCALE  = 3'd1,
        REG_RTD_SCALE      = 3'd2,
        REG_SETPOINT       = 3'd3,
        REG_DUTY_GAIN      = 3'd4,
        REG_TEMP_OUT_SCALE = 3'd5
    } cfg_reg_t;

    // RTD reading of each table point (table units)
    function automatic logic [RAW_W-1:0] tbl_raw(input logic [SEG_W-1:0] idx);
        logic [RAW_W-1:0] v;
        case (idx)
            5'd0:    v = 13'd0;
            5'd1:    v = 13'd347;
            5'd2:    v = 13'd678;
            5'd3:    v = 13'd948;
            5'd4:    v = 13'd1173;
            5'd5:    v = 13'd1365;
            5'd6:    v = 13'd1531;
            5'd7:    v = 13'd1676;
            5'd8:    v = 13'd1803;
            5'd9:    v = 13'd1916;
            5'd10:   v = 13'd2017;
            5'd11:   v = 13'd2107;
            5'd12:   v = 13'd2189;
            5'd13:   v = 13'd2263;
            5'd14:   v = 13'd2330;
            5'd15:   v = 13'd2392;
            5'd16:   v = 13'd2448;
            5'd17:   v = 13'd2500;
            5'd18:   v = 13'd2809;
            5'd19:   v = 13'd4096;
            default: v = '0;
        endcase
        return v;
    endfunction

    // Temperature of each table point (degrees)
    function automatic logic signed [DEG_W-1:0] tbl_deg(input logic [SEG_W-1:0] idx);
        logic signed [DEG_W-1:0] v;
        case (idx)
            5'd0:    v = -16'sd242;
            5'd1:    v = -16'sd200;
            5'd2:    v = -16'sd150;
            5'd3:    v = -16'sd100;
            5'd4:    v = -16'sd50;
            5'd5:    v = 16'sd0;
            5'd6:    v = 16'sd50;
            5'd7:    v = 16'sd100;
            5'd8:    v = 16'sd150;
            5'd9:    v = 16'sd200;
            5'd10:   v = 16'sd250;
            5'd11:   v = 16'sd300;
            5'd12:   v = 16'sd350;
            5'd13:   v = 16'sd400;
            5'd14:   v = 16'sd450;
            5'd15:   v = 16'sd500;
            5'd16:   v = 16'sd550;
            5'd17:   v = 16'sd600;
            5'd18:   v = 16'sd999;
            5'd19:   v = 16'sd32767;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/core/rtdhd_div_pipe.sv =====
// Pipelined restoring divider with its own valid/ready handshake and side payload.
// Depends on nothing but its parameters; instantiated by rtd_temperature_heater_drive.
module rtdhd_div_pipe #(
    parameter int NUM_W     = 36,
    parameter int DEN_W     = 11,
    parameter int SIDE_W    = 64,
    parameter int STEP_BITS = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [NUM_W-1:0]  in_num,
    input  logic [DEN_W-1:0]  in_den,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [NUM_W-1:0]  out_quot,
    output logic [SIDE_W-1:0] out_side
);

    localparam int STAGES = (NUM_W + STEP_BITS - 1) / STEP_BITS;
    localparam int PAD_W  = STAGES * STEP_BITS;

    // numerator bits leave at the top of nq, quotient bits enter at the bottom
    logic [STAGES-1:0] vld_reg;
    logic [STAGES-1:0] adv;
    logic [STAGES-1:0] src_vld;
    logic [DEN_W-1:0]  rem_reg  [STAGES];
    logic [DEN_W-1:0]  den_reg  [STAGES];
    logic [PAD_W-1:0]  nq_reg   [STAGES];
    logic [SIDE_W-1:0] side_reg [STAGES];
    logic [DEN_W-1:0]  src_rem  [STAGES];
    logic [DEN_W-1:0]  src_den  [STAGES];
    logic [PAD_W-1:0]  src_nq   [STAGES];
    logic [SIDE_W-1:0] src_side [STAGES];
    logic [DEN_W+PAD_W-1:0] step_next [STAGES];

    function automatic logic [DEN_W+PAD_W-1:0] div_step(
        input logic [DEN_W-1:0] rem_in,
        input logic [PAD_W-1:0] nq_in,
        input logic [DEN_W-1:0] den
    );
        logic [DEN_W:0]   wide;
        logic [DEN_W-1:0] rem;
        logic [PAD_W-1:0] nq;
        rem = rem_in;
        nq  = nq_in;
        for (int i = 0; i < STEP_BITS; i++)
        begin
            wide = {rem, nq[PAD_W-1]};
            if (wide >= {1'b0, den})
            begin
                wide = wide - {1'b0, den};
                nq   = {nq[PAD_W-2:0], 1'b1};
            end
            else
            begin
                nq   = {nq[PAD_W-2:0], 1'b0};
            end
            rem = wide[DEN_W-1:0];
        end
        return {rem, nq};
    endfunction

    always_comb
    begin
        for (int k = 0; k < STAGES; k++)
        begin
            if (k == 0)
            begin
                src_vld[k]  = in_valid;
                src_rem[k]  = '0;
                src_den[k]  = in_den;
                src_nq[k]   = PAD_W'(in_num);
                src_side[k] = in_side;
            end
            else
            begin
                src_vld[k]  = vld_reg[k-1];
                src_rem[k]  = rem_reg[k-1];
                src_den[k]  = den_reg[k-1];
                src_nq[k]   = nq_reg[k-1];
                src_side[k] = side_reg[k-1];
            end
            step_next[k] = div_step(src_rem[k], src_nq[k], src_den[k]);
        end
    end

    // a stage moves when it is empty or the one after it moves
    always_comb
    begin
        adv[STAGES-1] = ~vld_reg[STAGES-1] | out_ready;
        for (int k = STAGES - 2; k >= 0; k--)
        begin
            adv[k] = ~vld_reg[k] | adv[k+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < STAGES; k++)
            begin
                if (adv[k])
                begin
                    vld_reg[k] <= src_vld[k];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < STAGES; k++)
        begin
            if (adv[k] && src_vld[k])
            begin
                rem_reg[k]  <= step_next[k][PAD_W +: DEN_W];
                nq_reg[k]   <= step_next[k][PAD_W-1:0];
                den_reg[k]  <= src_den[k];
                side_reg[k] <= src_side[k];
            end
        end
    end

    assign in_ready  = adv[0];
    assign out_valid = vld_reg[STAGES-1];
    assign out_quot  = nq_reg[STAGES-1][NUM_W-1:0];
    assign out_side  = side_reg[STAGES-1];

`ifndef SYNTHESIS
    a_div_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |-> in_den != '0)
        else $error("divider fed a zero divisor");

    a_div_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> rem_reg[STAGES-1] < den_reg[STAGES-1])
        else $error("final remainder not below divisor");

    a_div_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> &vld_reg)
        else $error("divider refused a request with an empty stage");
`endif

endmodule

// ===== rtl/core/rtd_temperature_heater_drive.sv =====
// Top level of the RTD temperature reader and heater drive pipeline.
// Depends on rtdhd_pkg and rtdhd_div_pipe.
//
// Usage:
//   s_axis carries one request per sampling period: the battery and RTD pulse
//   counts. m_axis returns battery voltage, RTD reading, temperature, duty and
//   the heater flag for that request. The cfg port writes one register per
//   cycle when cfg_we is high (index per rtdhd_pkg::cfg_reg_t); write it only
//   while no request is in flight. Unknown indexes are ignored.
//   With enable low, requests are still taken but produce no result.
// Pipeline: an accepted request passes 4 front stages, 9 divider stages and
//   4 back stages before its result is loaded into the output register. The
//   divider depth follows from the 36-bit interpolation numerator, 4 quotient
//   bits per stage. Bubbles are squeezed out on the way.
// Throughput: one request per clock while m_axis is not stalled. Each stage
//   holds its item until the next stage has room, so a stalled receiver backs
//   up stage by stage; s_axis_tready drops only once every stage is full.
// Reset: all valid bits clear, the pipeline is empty, registers take their
//   defaults (enabled, unit scales and gains, setpoint 0).
module rtd_temperature_heater_drive #(
    parameter int TABLE_ENTRIES = rtdhd_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // request channel
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // [14:0] battery_count, [29:15] rtd_count, [31:30] zero
    input  logic [rtdhd_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // result channel
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // [31:0] battery_voltage, [52:32] rtd_reading, [72:53] temperature,
    // [104:73] duty, [105] heater_on, [111:106] zero
    output logic [rtdhd_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    // configuration write port
    input  logic                                  cfg_we,
    input  logic [rtdhd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [rtdhd_pkg::CFG_W-1:0]           cfg_wdata
);

    // points actually used from the table
    localparam int TABLE_USED = (TABLE_ENTRIES < rtdhd_pkg::TABLE_POINTS)
                              ? ((TABLE_ENTRIES < 2) ? 2 : TABLE_ENTRIES)
                              : rtdhd_pkg::TABLE_POINTS;

    localparam int SEG_W    = rtdhd_pkg::SEG_W;
    localparam int BV_W     = rtdhd_pkg::BV_W;
    localparam int RR_W     = rtdhd_pkg::RR_W;
    localparam int TEMP_W   = rtdhd_pkg::TEMP_W;
    localparam int DUTY_W   = rtdhd_pkg::DUTY_W;
    localparam int QS       = rtdhd_pkg::Q_SHIFT;
    localparam int BPROD_W  = rtdhd_pkg::BC_W + rtdhd_pkg::SCALE_W;
    localparam int RPROD_W  = rtdhd_pkg::RC_W + rtdhd_pkg::SCALE_W;
    localparam int NUM_W    = rtdhd_pkg::NUM_W;
    localparam int DEN_W    = rtdhd_pkg::DEN_W;
    localparam int DEGL_W   = rtdhd_pkg::DEGL_W;
    localparam int Y_W      = rtdhd_pkg::Y_W;
    localparam int YW_W     = NUM_W + 1;
    localparam int P_W      = Y_W + rtdhd_pkg::TSCALE_W + 1;
    localparam int PS_W     = P_W - QS;
    localparam int DELTA_W  = TEMP_W + 1;
    localparam int PD_W     = DELTA_W + rtdhd_pkg::GAIN_W + 1;
    localparam int SIDE_W   = BV_W + RR_W + DEGL_W;
    localparam int F_STAGES = 4;
    localparam int B_STAGES = 5;
    localparam int OUT_PAD_W = rtdhd_pkg::OUT_TDATA_W - rtdhd_pkg::OUT_FIELDS_W;

    localparam logic signed [YW_W-1:0] Y_LIMIT = YW_W'(rtdhd_pkg::Y_CLAMP);
    localparam logic signed [PS_W-1:0] T_MAX   = PS_W'((1 << (TEMP_W - 1)) - 1);
    localparam logic signed [PS_W-1:0] T_MIN   = PS_W'(-(1 << (TEMP_W - 1)));

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic                                 enable_reg;
    logic [rtdhd_pkg::SCALE_W-1:0]        battery_scale_reg;
    logic [rtdhd_pkg::SCALE_W-1:0]        rtd_scale_reg;
    logic signed [rtdhd_pkg::SP_W-1:0]    setpoint_reg;
    logic [rtdhd_pkg::GAIN_W-1:0]         duty_gain_reg;
    logic [rtdhd_pkg::TSCALE_W-1:0]       temp_out_scale_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg         <= 1'b1;
            battery_scale_reg  <= 32'd65536;
            rtd_scale_reg      <= 32'd65536;
            setpoint_reg       <= '0;
            duty_gain_reg      <= 16'd256;
            temp_out_scale_reg <= 16'd256;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rtdhd_pkg::REG_ENABLE:         enable_reg         <= cfg_wdata[0];
                rtdhd_pkg::REG_BATTERY_SCALE:  battery_scale_reg  <= cfg_wdata;
                rtdhd_pkg::REG_RTD_SCALE:      rtd_scale_reg      <= cfg_wdata;
                rtdhd_pkg::REG_SETPOINT:
                    setpoint_reg <= cfg_wdata[rtdhd_pkg::SP_W-1:0];
                rtdhd_pkg::REG_DUTY_GAIN:
                    duty_gain_reg <= cfg_wdata[rtdhd_pkg::GAIN_W-1:0];
                rtdhd_pkg::REG_TEMP_OUT_SCALE:
                    temp_out_scale_reg <= cfg_wdata[rtdhd_pkg::TSCALE_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Front pipeline: scale, locate segment, segment lookup, numerator
    // ------------------------------------------------------------------
    logic [F_STAGES-1:0] f_vld_reg;
    logic [F_STAGES-1:0] f_vld_in;
    logic [F_STAGES-1:0] f_adv;
    logic [F_STAGES-1:0] f_load;
    logic                div_in_ready;

    logic [rtdhd_pkg::BC_W-1:0] in_bc;
    logic [rtdhd_pkg::RC_W-1:0] in_rc;

    assign in_bc = s_axis_tdata[rtdhd_pkg::BC_W-1:0];
    assign in_rc = s_axis_tdata[rtdhd_pkg::BC_W +: rtdhd_pkg::RC_W];

    // disabled requests are accepted and dropped right here
    assign f_vld_in[0] = s_axis_tvalid & enable_reg;
    assign f_vld_in[1] = f_vld_reg[0];
    assign f_vld_in[2] = f_vld_reg[1];
    assign f_vld_in[3] = f_vld_reg[2];

    assign f_adv[3] = ~f_vld_reg[3] | div_in_ready;
    assign f_adv[2] = ~f_vld_reg[2] | f_adv[3];
    assign f_adv[1] = ~f_vld_reg[1] | f_adv[2];
    assign f_adv[0] = ~f_vld_reg[0] | f_adv[1];
    assign f_load   = f_adv & f_vld_in;

    assign s_axis_tready = f_adv[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_vld_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < F_STAGES; k++)
            begin
                if (f_adv[k])
                begin
                    f_vld_reg[k] <= f_vld_in[k];
                end
            end
        end
    end

    // stage F1: raw products
    logic [BPROD_W-1:0] f1_bprod_reg, f1_bprod_next;
    logic [RPROD_W-1:0] f1_rprod_reg, f1_rprod_next;

    assign f1_bprod_next = BPROD_W'(in_bc) * BPROD_W'(battery_scale_reg);
    assign f1_rprod_next = RPROD_W'(in_rc) * RPROD_W'(rtd_scale_reg);

    always_ff @(posedge clk)
    begin
        if (f_load[0])
        begin
            f1_bprod_reg <= f1_bprod_next;
            f1_rprod_reg <= f1_rprod_next;
        end
    end

    // stage F2: saturate, pick segment
    logic [BV_W-1:0]  f2_bv_reg, f2_bv_next;
    logic [RR_W-1:0]  f2_rr_reg, f2_rr_next;
    logic [SEG_W-1:0] f2_seg_reg, f2_seg_next;
    logic [SEG_W-1:0] seg_right;

    assign f2_bv_next = (|f1_bprod_reg[BPROD_W-1:BV_W]) ? '1 : f1_bprod_reg[BV_W-1:0];
    assign f2_rr_next = (|f1_rprod_reg[RPROD_W-1:RR_W+QS]) ? '1
                                                            : f1_rprod_reg[RR_W+QS-1:QS];

    // right point: first point not below the reading, else the last point
    always_comb
    begin
        seg_right = SEG_W'(TABLE_USED - 1);
        for (int i = TABLE_USED - 2; i >= 0; i--)
        begin
            if (f2_rr_next <= {rtdhd_pkg::tbl_raw(SEG_W'(i)), QS'(0)})
            begin
                seg_right = SEG_W'(i);
            end
        end
        // a reading of zero still uses the first segment
        if (seg_right == '0)
        begin
            f2_seg_next = '0;
        end
        else
        begin
            f2_seg_next = seg_right - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (f_load[1])
        begin
            f2_bv_reg  <= f2_bv_next;
            f2_rr_reg  <= f2_rr_next;
            f2_seg_reg <= f2_seg_next;
        end
    end

    // stage F3: segment endpoints and offset into the segment
    logic [BV_W-1:0]              f3_bv_reg;
    logic [RR_W-1:0]              f3_rr_reg;
    logic [rtdhd_pkg::X_W-1:0]    f3_x_reg, f3_x_next;
    logic [rtdhd_pkg::DD_W-1:0]   f3_dd_reg, f3_dd_next;
    logic [DEN_W-1:0]             f3_den_reg, f3_den_next;
    logic signed [DEGL_W-1:0]     f3_degl_reg, f3_degl_next;
    logic [SEG_W-1:0]             seg_r_idx;
    logic [rtdhd_pkg::RAW_W-1:0]  raw_l, raw_r;
    logic signed [rtdhd_pkg::DEG_W-1:0] deg_l, deg_r, deg_step;
    logic [rtdhd_pkg::RAW_W-1:0]  raw_step;

    assign seg_r_idx    = f2_seg_reg + 1'b1;
    assign raw_l        = rtdhd_pkg::tbl_raw(f2_seg_reg);
    assign raw_r        = rtdhd_pkg::tbl_raw(seg_r_idx);
    assign deg_l        = rtdhd_pkg::tbl_deg(f2_seg_reg);
    assign deg_r        = rtdhd_pkg::tbl_deg(seg_r_idx);
    assign deg_step     = deg_r - deg_l;
    assign raw_step     = raw_r - raw_l;
    // reading is never below the left point of its segment
    assign f3_x_next    = f2_rr_reg - {raw_l, QS'(0)};
    assign f3_dd_next   = deg_step[rtdhd_pkg::DD_W-1:0];
    assign f3_den_next  = raw_step[DEN_W-1:0];
    assign f3_degl_next = deg_l[DEGL_W-1:0];

    always_ff @(posedge clk)
    begin
        if (f_load[2])
        begin
            f3_bv_reg   <= f2_bv_reg;
            f3_rr_reg   <= f2_rr_reg;
            f3_x_reg    <= f3_x_next;
            f3_dd_reg   <= f3_dd_next;
            f3_den_reg  <= f3_den_next;
            f3_degl_reg <= f3_degl_next;
        end
    end

    // stage F4: interpolation numerator
    logic [NUM_W-1:0]  f4_num_reg, f4_num_next;
    logic [DEN_W-1:0]  f4_den_reg;
    logic [SIDE_W-1:0] f4_side_reg;

    assign f4_num_next = NUM_W'(f3_dd_reg) * NUM_W'(f3_x_reg);

    always_ff @(posedge clk)
    begin
        if (f_load[3])
        begin
            f4_num_reg  <= f4_num_next;
            f4_den_reg  <= f3_den_reg;
            f4_side_reg <= {f3_degl_reg, f3_rr_reg, f3_bv_reg};
        end
    end

    // ------------------------------------------------------------------
    // Segment divide
    // ------------------------------------------------------------------
    logic              div_out_valid;
    logic              div_out_ready;
    logic [NUM_W-1:0]  div_quot;
    logic [SIDE_W-1:0] div_side;

    rtdhd_div_pipe #(
        .NUM_W     (NUM_W),
        .DEN_W     (DEN_W),
        .SIDE_W    (SIDE_W),
        .STEP_BITS (4)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_vld_reg[3]),
        .in_ready  (div_in_ready),
        .in_num    (f4_num_reg),
        .in_den    (f4_den_reg),
        .in_side   (f4_side_reg),
        .out_valid (div_out_valid),
        .out_ready (div_out_ready),
        .out_quot  (div_quot),
        .out_side  (div_side)
    );

    // ------------------------------------------------------------------
    // Back pipeline: temperature, output scale, error and duty
    // ------------------------------------------------------------------
    logic [B_STAGES-1:0] b_vld_reg;
    logic [B_STAGES-1:0] b_vld_in;
    logic [B_STAGES-1:0] b_adv;
    logic [B_STAGES-1:0] b_load;

    assign b_vld_in[0] = div_out_valid;
    assign b_vld_in[1] = b_vld_reg[0];
    assign b_vld_in[2] = b_vld_reg[1];
    assign b_vld_in[3] = b_vld_reg[2];
    assign b_vld_in[4] = b_vld_reg[3];

    assign b_adv[4] = ~b_vld_reg[4] | m_axis_tready;
    assign b_adv[3] = ~b_vld_reg[3] | b_adv[4];
    assign b_adv[2] = ~b_vld_reg[2] | b_adv[3];
    assign b_adv[1] = ~b_vld_reg[1] | b_adv[2];
    assign b_adv[0] = ~b_vld_reg[0] | b_adv[1];
    assign b_load   = b_adv & b_vld_in;

    assign div_out_ready = b_adv[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_vld_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < B_STAGES; k++)
            begin
                if (b_adv[k])
                begin
                    b_vld_reg[k] <= b_vld_in[k];
                end
            end
        end
    end

    // stage B1: temperature before scaling, clamped high
    logic [BV_W-1:0]          b1_bv_reg;
    logic [RR_W-1:0]          b1_rr_reg;
    logic signed [Y_W-1:0]    b1_y_reg, b1_y_next;
    logic signed [DEGL_W-1:0] side_degl;
    logic signed [YW_W-1:0]   y_wide;

    assign side_degl = div_side[BV_W+RR_W +: DEGL_W];
    assign y_wide    = $signed({1'b0, div_quot})
                     + $signed({{(YW_W-DEGL_W-QS){side_degl[DEGL_W-1]}}, side_degl, QS'(0)});
    // quotient is non-negative, so only the top needs clamping
    assign b1_y_next = (y_wide > Y_LIMIT) ? Y_W'(Y_LIMIT) : Y_W'(y_wide);

    always_ff @(posedge clk)
    begin
        if (b_load[0])
        begin
            b1_bv_reg <= div_side[BV_W-1:0];
            b1_rr_reg <= div_side[BV_W +: RR_W];
            b1_y_reg  <= b1_y_next;
        end
    end

    // stage B2: output scale product
    logic [BV_W-1:0]       b2_bv_reg;
    logic [RR_W-1:0]       b2_rr_reg;
    logic signed [P_W-1:0] b2_p_reg, b2_p_next;

    assign b2_p_next = P_W'(b1_y_reg) * P_W'($signed({1'b0, temp_out_scale_reg}));

    always_ff @(posedge clk)
    begin
        if (b_load[1])
        begin
            b2_bv_reg <= b1_bv_reg;
            b2_rr_reg <= b1_rr_reg;
            b2_p_reg  <= b2_p_next;
        end
    end

    // stage B3: floor to Q11.8 and saturate
    logic [BV_W-1:0]          b3_bv_reg;
    logic [RR_W-1:0]          b3_rr_reg;
    logic signed [TEMP_W-1:0] b3_t_reg, b3_t_next;
    logic signed [PS_W-1:0]   p_shift;

    assign p_shift = $signed(b2_p_reg[P_W-1:QS]);

    always_comb
    begin
        if (p_shift > T_MAX)
        begin
            b3_t_next = TEMP_W'(T_MAX);
        end
        else if (p_shift < T_MIN)
        begin
            b3_t_next = TEMP_W'(T_MIN);
        end
        else
        begin
            b3_t_next = TEMP_W'(p_shift);
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_load[2])
        begin
            b3_bv_reg <= b2_bv_reg;
            b3_rr_reg <= b2_rr_reg;
            b3_t_reg  <= b3_t_next;
        end
    end

    // stage B4: error from setpoint times gain
    logic [BV_W-1:0]           b4_bv_reg;
    logic [RR_W-1:0]           b4_rr_reg;
    logic signed [TEMP_W-1:0]  b4_t_reg;
    logic signed [PD_W-1:0]    b4_pd_reg, b4_pd_next;
    logic                      b4_heater_reg, b4_heater_next;
    logic signed [DELTA_W-1:0] delta;

    assign delta          = DELTA_W'(setpoint_reg) - DELTA_W'(b3_t_reg);
    assign b4_pd_next     = PD_W'(delta) * PD_W'($signed({1'b0, duty_gain_reg}));
    assign b4_heater_next = (delta != '0);

    always_ff @(posedge clk)
    begin
        if (b_load[3])
        begin
            b4_bv_reg     <= b3_bv_reg;
            b4_rr_reg     <= b3_rr_reg;
            b4_t_reg      <= b3_t_reg;
            b4_pd_reg     <= b4_pd_next;
            b4_heater_reg <= b4_heater_next;
        end
    end

    // stage B5: output register; the floored product always fits 32 bits
    logic [BV_W-1:0]          out_bv_reg;
    logic [RR_W-1:0]          out_rr_reg;
    logic signed [TEMP_W-1:0] out_temp_reg;
    logic signed [DUTY_W-1:0] out_duty_reg, out_duty_next;
    logic                     out_heater_reg;

    assign out_duty_next = DUTY_W'($signed(b4_pd_reg[PD_W-1:QS]));

    always_ff @(posedge clk)
    begin
        if (b_load[4])
        begin
            out_bv_reg     <= b4_bv_reg;
            out_rr_reg     <= b4_rr_reg;
            out_temp_reg   <= b4_t_reg;
            out_duty_reg   <= out_duty_next;
            out_heater_reg <= b4_heater_reg;
        end
    end

    assign m_axis_tvalid = b_vld_reg[4];
    assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, out_heater_reg, out_duty_reg,
                            out_temp_reg, out_rr_reg, out_bv_reg};

`ifndef SYNTHESIS
    a_disabled_drop: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && !enable_reg |=> !f_vld_reg[0])
        else $error("request taken while disabled entered the pipeline");

    a_seg_range: assert property (@(posedge clk) disable iff (!rst_n)
        f_vld_reg[1] |-> f2_seg_reg <= SEG_W'(TABLE_USED - 2))
        else $error("segment index beyond the table in use");

    a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        f_vld_reg[2] |-> f3_den_reg != '0)
        else $error("segment with zero reading step");

    a_heater_duty: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && out_duty_reg != '0 |-> out_heater_reg)
        else $error("nonzero duty with heater off");
`endif

endmodule

// ===== tb/rtd_temperature_heater_drive_test.sv =====
// Self-checking testbench for rtd_temperature_heater_drive: drives count pairs,
// predicts each reading in fixed point and checks the result stream.
// Depends on rtdhd_pkg (widths, register map) and the block itself.
module rtd_temperature_heater_drive_test;

    import rtdhd_pkg::*;

    // Points of the RTD curve in use; the instance gets the same value.
    localparam int PT_COUNT     = TABLE_ENTRIES_DEF;
    // Settle time before a register write or the end.
    localparam int DRAIN_CYCLES = 40;
    localparam int RAND_PHASES  = 9;
    localparam int RAND_ITEMS   = 125;
    localparam int MAX_REPORTS  = 10;
    // Indexes past the register map, must be ignored by the block.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [RC_W-1:0] rtd_count;
        logic [BC_W-1:0] battery_count;
    } count_pair_t;

    typedef struct packed {
        logic            heater_on;
        logic [DUTY_W-1:0] duty;
        logic [TEMP_W-1:0] temperature;
        logic [RR_W-1:0]   rtd_reading;
        logic [BV_W-1:0]   battery_voltage;
    } reading_t;

    // RTD curve: reading in table units and degrees at each point.
    int pt_raw [PT_COUNT] = '{0, 347, 678, 948, 1173, 1365, 1531, 1676, 1803, 1916,
                              2017, 2107, 2189, 2263, 2330, 2392, 2448, 2500, 2809, 4096};
    int pt_deg [PT_COUNT] = '{-242, -200, -150, -100, -50, 0, 50, 100, 150, 200,
                              250, 300, 350, 400, 450, 500, 550, 600, 999, 32767};

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_W-1:0]       cfg_wdata = '0;

    // Shadow copy of the register file, reset values.
    logic                     cfg_enable         = 1'b1;
    logic [SCALE_W-1:0]       cfg_battery_scale  = 32'd65536;
    logic [SCALE_W-1:0]       cfg_rtd_scale      = 32'd65536;
    logic signed [SP_W-1:0]   cfg_setpoint       = '0;
    logic [GAIN_W-1:0]        cfg_duty_gain      = 16'd256;
    logic [TSCALE_W-1:0]      cfg_temp_out_scale = 16'd256;

    count_pair_t count_requests [$];   // pairs waiting to be sent
    reading_t    due_readings [$];     // readings predicted, not yet seen
    count_pair_t cur_pair   = '0;
    bit          loaded     = 1'b0;    // cur_pair is on the bus
    bit          quiet_run  = 1'b0;    // no idling on either side
    int          gap_left   = 0;
    int          stall_left = 0;
    int          mismatch_count = 0;

    rtd_temperature_heater_drive #(
        .TABLE_ENTRIES(PT_COUNT)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // Fixed-point reading for one count pair under the shadow registers.
    // Divisions truncate toward zero, Q shifts floor, every field clamps.
    function automatic reading_t predict_reading(input logic [BC_W-1:0] bc,
                                                 input logic [RC_W-1:0] rc);
        reading_t        res;
        longint unsigned bv;
        longint unsigned rr;
        longint          y;
        longint          t;
        longint          delta;
        longint          duty;
        int              seg_r;
        int              seg_l;
        bv = 64'(bc) * 64'(cfg_battery_scale);
        if (bv > 64'hffff_ffff)
            bv = 64'hffff_ffff;
        rr = (64'(rc) * 64'(cfg_rtd_scale)) >> Q_SHIFT;
        if (rr > 64'h1f_ffff)
            rr = 64'h1f_ffff;
        // right point: first of 0..n-2 at or above the reading, else n-1
        seg_r = PT_COUNT - 1;
        for (int k = PT_COUNT - 2; k >= 0; k--)
            if (rr <= 64'(pt_raw[k]) * 256)
                seg_r = k;
        // a reading of zero still interpolates on the first segment
        if (seg_r < 1)
            seg_r = 1;
        seg_l = seg_r - 1;
        y = longint'(pt_deg[seg_l]) * 256
            + (longint'(pt_deg[seg_r] - pt_deg[seg_l])
               * ($signed(rr) - longint'(pt_raw[seg_l]) * 256))
              / longint'(pt_raw[seg_r] - pt_raw[seg_l]);
        t = (y * longint'(cfg_temp_out_scale)) >>> Q_SHIFT;
        if (t < -524288)
            t = -524288;
        else if (t > 524287)
            t = 524287;
        delta = longint'(cfg_setpoint) - t;
        duty = (delta * longint'(cfg_duty_gain)) >>> Q_SHIFT;
        if (duty < -64'sd2147483648)
            duty = -64'sd2147483648;
        else if (duty > 64'sd2147483647)
            duty = 64'sd2147483647;
        res.battery_voltage = bv[BV_W-1:0];
        res.rtd_reading     = rr[RR_W-1:0];
        res.temperature     = t[TEMP_W-1:0];
        res.duty            = duty[DUTY_W-1:0];
        res.heater_on       = (delta != 0);
        return res;
    endfunction

    // Request driver: one pair at a time from count_requests, a random
    // idle gap after each accepted request. The reading is predicted at the
    // accepting edge; with enable low nothing is expected back.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            loaded   = 1'b0;
            gap_left = 0;
            s_axis_tvalid <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                if (cfg_enable)
                    due_readings.push_back(predict_reading(cur_pair.battery_count,
                                                           cur_pair.rtd_count));
                loaded   = 1'b0;
                gap_left = quiet_run ? 0 : $urandom_range(0, 15);
            end
            if (!loaded)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (count_requests.size() != 0)
                begin
                    cur_pair = count_requests.pop_front();
                    loaded   = 1'b1;
                end
            end
            s_axis_tvalid <= loaded;
            s_axis_tdata  <= IN_TDATA_W'(cur_pair);
        end
    end

    // Result monitor: random back-pressure after each taken result, every
    // result checked against the oldest prediction.
    always @(posedge clk)
    begin
        reading_t want;
        reading_t got;
        if (!rst_n)
        begin
            stall_left = 0;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = reading_t'(m_axis_tdata[OUT_FIELDS_W-1:0]);
                if (due_readings.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("unexpected result: tdata %h", m_axis_tdata);
                end
                else
                begin
                    want = due_readings.pop_front();
                    if (got.battery_voltage !== want.battery_voltage
                        || got.rtd_reading !== want.rtd_reading
                        || got.temperature !== want.temperature
                        || got.duty !== want.duty
                        || got.heater_on !== want.heater_on)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS)
                            $display("mismatch: bv %0d/%0d rr %0d/%0d temp %0d/%0d duty %0d/%0d heat %0b/%0b (exp/act)",
                                     want.battery_voltage, got.battery_voltage,
                                     want.rtd_reading, got.rtd_reading,
                                     $signed(want.temperature), $signed(got.temperature),
                                     $signed(want.duty), $signed(got.duty),
                                     want.heater_on, got.heater_on);
                    end
                end
                stall_left = quiet_run ? 0 : $urandom_range(0, 15);
            end
            else if (stall_left > 0)
                stall_left--;
            m_axis_tready <= (stall_left == 0);
        end
    end

    // One register write per call; cfg_we stays high across back-to-back
    // writes and is dropped by end_writes. Shadow copy masks like the block.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_ENABLE:         cfg_enable         = val[0];
            REG_BATTERY_SCALE:  cfg_battery_scale  = val;
            REG_RTD_SCALE:      cfg_rtd_scale      = val;
            REG_SETPOINT:       cfg_setpoint       = val[SP_W-1:0];
            REG_DUTY_GAIN:      cfg_duty_gain      = val[GAIN_W-1:0];
            REG_TEMP_OUT_SCALE: cfg_temp_out_scale = val[TSCALE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic end_writes();
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic queue_pair(input int bc, input int rc);
        count_pair_t p;
        p.battery_count = bc[BC_W-1:0];
        p.rtd_count     = rc[RC_W-1:0];
        count_requests.push_back(p);
    endtask

    // Waits until every queued pair is sent and every reading is back,
    // then lets the tail settle (disabled requests leave nothing to wait for).
    task automatic drain_pipeline();
        do
            @(negedge clk);
        while (count_requests.size() != 0 || loaded || due_readings.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Random pair: mostly readings on the curve, plus point hits and
    // full-range noise so the saturation and extrapolation paths get hit.
    task automatic queue_random_pair();
        int bc;
        int rc;
        bc = $urandom_range(0, 32767);
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: rc = $urandom_range(0, 4200);
            6:                rc = pt_raw[$urandom_range(0, PT_COUNT - 1)];
            7:                rc = $urandom_range(0, 32767);
            8:                rc = 0;
            default:          rc = $urandom_range(32000, 32767);
        endcase
        queue_pair(bc, rc);
    endtask

    task automatic write_random_config();
        logic [CFG_W-1:0] v;
        write_reg(REG_ENABLE, 32'd1);
        case ($urandom_range(0, 3))
            0:       v = $urandom;
            1:       v = 32'hffff_ffff;
            2:       v = 32'd0;
            default: v = $urandom_range(0, 32'h0002_0000);
        endcase
        write_reg(REG_BATTERY_SCALE, v);
        if ($urandom_range(0, 3) == 0)
            v = $urandom;
        else
            v = $urandom_range(32'h0000_8000, 32'h0001_8000);
        write_reg(REG_RTD_SCALE, v);
        // table points make a zero error likely
        if ($urandom_range(0, 1) == 0)
            v = pt_deg[$urandom_range(0, PT_COUNT - 2)] * 256;
        else
            v = $urandom;
        write_reg(REG_SETPOINT, v);
        write_reg(REG_DUTY_GAIN, $urandom_range(0, 65535));
        if ($urandom_range(0, 2) == 0)
            v = $urandom_range(0, 65535);
        else
            v = $urandom_range(128, 512);
        write_reg(REG_TEMP_OUT_SCALE, v);
        end_writes();
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset values: unit scales, so rtd_count lands straight on the curve.
        queue_pair(0, 0);              // zero reading, first segment
        queue_pair(32767, 32767);      // reading saturates, extrapolated
        queue_pair(1, 1);
        queue_pair(0, 347);            // on a point
        queue_pair(0, 348);
        queue_pair(0, 1365);           // zero degrees: error zero, heater off
        queue_pair(0, 2809);
        queue_pair(0, 4096);           // last point
        queue_pair(0, 4097);           // past the table end
        queue_pair(21845, 10922);
        queue_pair(10922, 21845);
        drain_pipeline();

        // Register maxima: battery and temperature saturate.
        write_reg(REG_BATTERY_SCALE, 32'hffff_ffff);
        write_reg(REG_RTD_SCALE, 32'hffff_ffff);
        write_reg(REG_SETPOINT, 32'h0007_ffff);
        write_reg(REG_DUTY_GAIN, 32'h0000_ffff);
        write_reg(REG_TEMP_OUT_SCALE, 32'h0000_ffff);
        end_writes();
        queue_pair(0, 0);
        queue_pair(32767, 32767);
        queue_pair(2, 1);
        queue_pair(32767, 0);
        drain_pipeline();

        // Register minima; upper data bits of the setpoint must be dropped.
        write_reg(REG_BATTERY_SCALE, 32'd0);
        write_reg(REG_RTD_SCALE, 32'd0);
        write_reg(REG_SETPOINT, 32'hfff8_0000);
        write_reg(REG_DUTY_GAIN, 32'hffff_0000);
        write_reg(REG_TEMP_OUT_SCALE, 32'd0);
        end_writes();
        queue_pair(32767, 32767);
        queue_pair(0, 0);
        queue_pair(12345, 2500);
        drain_pipeline();

        // Disabled (bit 0 only counts), spare indexes ignored: no results.
        write_reg(REG_ENABLE, 32'hffff_fffe);
        write_reg(REG_SPARE_LO, 32'hffff_ffff);
        write_reg(REG_SPARE_HI, 32'h1234_5678);
        end_writes();
        queue_pair(32767, 32767);
        queue_pair(0, 0);
        queue_pair(100, 1000);
        drain_pipeline();

        // Random settings, each phase ends with a full drain before rewrite.
        for (int p = 0; p < RAND_PHASES; p++)
        begin
            write_random_config();
            quiet_run = (p == 2 || p == 6);
            for (int n = 0; n < RAND_ITEMS; n++)
                queue_random_pair();
            drain_pipeline();
        end
        quiet_run = 1'b0;

        if (mismatch_count == 0 && due_readings.size() == 0)
            $display("rtd_temperature_heater_drive regression: pass");
        else
            $display("rtd_temperature_heater_drive regression: fail");
        $finish;
    end

    // Hang guard, far beyond the slowest legal run.
    initial
    begin
        #20_000_000;
        $display("rtd_temperature_heater_drive regression: fail");
        $finish;
    end

endmodule
